// ===== hdl/channel_priority_interrupt_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller: assertion macros
// Shared macros for concurrent checks clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH
`define CHANNEL_PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define CPIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CPIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cpic_pkg.sv =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller: package
// Shared types, codes and defaults.
// ----------------------------------------------------------------------------
package cpic_pkg;

    localparam int DEF_NUM_SOURCES = 128;
    localparam logic [31:0] NONE_NUMBER = 32'h8000_0000;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_PULSE = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ADDR = 3'd1;
    localparam logic [2:0] ST_RO_WRITE = 3'd2;
    localparam logic [2:0] ST_BAD_SRC  = 3'd3;
    localparam logic [2:0] ST_WO_READ  = 3'd4;

    // Operations of the source memory sweep.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_CLEAR     = 4'd1;
    localparam logic [3:0] OP_SCAN      = 4'd2;
    localparam logic [3:0] OP_SET_PEND  = 4'd3;
    localparam logic [3:0] OP_CLR_PEND  = 4'd4;
    localparam logic [3:0] OP_SET_EN    = 4'd5;
    localparam logic [3:0] OP_CLR_EN    = 4'd6;
    localparam logic [3:0] OP_RD_PEND   = 4'd7;
    localparam logic [3:0] OP_RD_PENDEN = 4'd8;
    localparam logic [3:0] OP_RD_EN     = 4'd9;
    localparam logic [3:0] OP_RD_MAP    = 4'd10;
    localparam logic [3:0] OP_WR_MAP    = 4'd11;

    // Flat registers.
    localparam logic [3:0] R_NONE    = 4'd0;
    localparam logic [3:0] R_REV     = 4'd1;
    localparam logic [3:0] R_CTRL    = 4'd2;
    localparam logic [3:0] R_GEN     = 4'd3;
    localparam logic [3:0] R_VBASE   = 4'd4;
    localparam logic [3:0] R_VSTRIDE = 4'd5;
    localparam logic [3:0] R_NULL    = 4'd6;
    localparam logic [3:0] R_NUM0    = 4'd7;
    localparam logic [3:0] R_VEC0    = 4'd8;
    localparam logic [3:0] R_NUM1    = 4'd9;
    localparam logic [3:0] R_NUM2    = 4'd10;
    localparam logic [3:0] R_VEC1    = 4'd11;
    localparam logic [3:0] R_VEC2    = 4'd12;
    localparam logic [3:0] R_HOST    = 4'd13;
    localparam logic [3:0] R_HSET    = 4'd14;
    localparam logic [3:0] R_HCLR    = 4'd15;

    typedef struct packed {
        logic       pend;
        logic       en;
        logic [7:0] ch;
    } entry_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] op;
        logic [3:0] sel;
        logic       single;
        logic       scan;
    } dec_t;

endpackage

// ===== hdl/channel_priority_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller
// Register-mapped vectored interrupt controller with per-source pending,
// enable and channel state held in one synchronous memory.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Every read, write and pulse passes a decode
// step and an output step; memory work walks the source memory one entry
// per cycle and then waits for the registered read data: 4 entries for a
// channel map word, 32 for a bank word, 1 for an index write or a pulse. Any
// write or pulse that changes state then scans all NUM_SOURCES entries and
// computes the FIQ and IRQ vectors in the S_VEC_F and S_VEC_I steps. A result
// still waiting on m_tready holds the next one in its output step. After reset
// a clearing pass over all NUM_SOURCES entries zeroes the memory; no item is
// taken during it, while revision writes on cfg_wen are accepted at any time.
// ----------------------------------------------------------------------------
`include "channel_priority_interrupt_controller_defines.svh"

module channel_priority_interrupt_controller
    import cpic_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] address, [63:32] write_data, [70:64] source, [71] zero
    input  logic [71:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] fiq_line, [33] irq_line, [36:34] status, [39:37] zero
    output logic [39:0] m_tdata
);

    localparam int AW = $clog2(NUM_SOURCES);
    localparam int CW = $clog2(NUM_SOURCES + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_RUN   = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_VEC_F = 4'd5;
    localparam logic [3:0] S_VEC_I = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]    state_reg;
    logic [1:0]    act_reg;
    logic [31:0]   addr_reg;
    logic [31:0]   data_reg;
    logic [6:0]    src_reg;
    dec_t          dec;
    logic [AW-1:0] dec_start;
    logic [2:0]    status_reg;
    logic          scan_pend_reg;
    logic          single_reg;

    logic [3:0]    op_reg;
    logic [AW-1:0] start_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] cnt_reg;
    logic          dv_reg;
    logic [AW-1:0] d_addr_reg;
    logic [4:0]    d_off_reg;

    logic [31:0]   rev_reg;
    logic [31:0]   ctrl_reg;
    logic          gen_reg;
    logic [1:0]    host_reg;
    logic [31:0]   vbase_reg;
    logic [31:0]   vstride_reg;
    logic [31:0]   null_reg;
    logic          fv_reg;
    logic          iv_reg;
    logic [AW-1:0] fidx_reg;
    logic [AW-1:0] iidx_reg;
    logic [7:0]    fch_reg;
    logic [7:0]    ich_reg;
    logic [31:0]   vec1_reg;
    logic [31:0]   vec2_reg;
    logic [31:0]   rd_reg;

    logic          m_valid_reg;
    logic [39:0]   m_data_reg;

    logic          mem_we;
    entry_t        mem_wdata;
    entry_t        mem_rdata;
    logic [AW-1:0] mem_raddr;
    logic          bit_sel;
    logic [31:0]   num1;
    logic [31:0]   num2;
    logic          glob_f;
    logic [31:0]   reg_rd;
    logic [CW-1:0] op_len;
    logic [AW-1:0] mul_idx;
    logic [31:0]   mul_prod;
    logic          hit;

    cpic_decode #(
        .NUM_SOURCES(NUM_SOURCES),
        .AW         (AW)
    ) u_decode (
        .action    (act_reg),
        .address   (addr_reg),
        .write_data(data_reg),
        .source    (src_reg),
        .dec       (dec),
        .start     (dec_start)
    );

    cpic_src_ram #(
        .DEPTH(NUM_SOURCES),
        .AW   (AW)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(d_addr_reg),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign mem_raddr = AW'(start_reg + AW'(cnt_reg));

    assign num1   = fv_reg ? {{(32 - AW){1'b0}}, fidx_reg} : NONE_NUMBER;
    assign num2   = iv_reg ? {{(32 - AW){1'b0}}, iidx_reg} : NONE_NUMBER;
    assign glob_f = fv_reg || !iv_reg;

    assign mul_idx  = (state_reg == S_VEC_F) ? fidx_reg : iidx_reg;
    assign mul_prod = 32'(vstride_reg * {{(32 - AW){1'b0}}, mul_idx});

    always_comb begin
        unique case (dec.sel)
            R_REV:     reg_rd = rev_reg;
            R_CTRL:    reg_rd = ctrl_reg;
            R_GEN:     reg_rd = {31'd0, gen_reg};
            R_VBASE:   reg_rd = vbase_reg;
            R_VSTRIDE: reg_rd = vstride_reg;
            R_NULL:    reg_rd = null_reg;
            R_NUM0:    reg_rd = glob_f ? num1 : num2;
            R_VEC0:    reg_rd = glob_f ? vec1_reg : vec2_reg;
            R_NUM1:    reg_rd = num1;
            R_NUM2:    reg_rd = num2;
            R_VEC1:    reg_rd = vec1_reg;
            R_VEC2:    reg_rd = vec2_reg;
            R_HOST:    reg_rd = {30'd0, host_reg};
            default:   reg_rd = 32'd0;
        endcase
    end

    always_comb begin
        unique case (dec.op)
            OP_RD_MAP, OP_WR_MAP: op_len = CW'(4);
            default:              op_len = dec.single ? CW'(1) : CW'(32);
        endcase
    end

    // Read-modify-write of the entry whose data returns this cycle.
    assign bit_sel = single_reg ? 1'b1 : data_reg[d_off_reg];
    assign hit     = mem_rdata.pend && mem_rdata.en;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        if (dv_reg) begin
            unique case (op_reg)
                OP_CLEAR: begin
                    mem_we    = 1'b1;
                    mem_wdata = '0;
                end
                OP_SET_PEND: begin mem_we = bit_sel; mem_wdata.pend = 1'b1; end
                OP_CLR_PEND: begin mem_we = bit_sel; mem_wdata.pend = 1'b0; end
                OP_SET_EN:   begin mem_we = bit_sel; mem_wdata.en = 1'b1; end
                OP_CLR_EN:   begin mem_we = bit_sel; mem_wdata.en = 1'b0; end
                OP_WR_MAP: begin
                    mem_we       = 1'b1;
                    mem_wdata.ch = data_reg[{d_off_reg[1:0], 3'b000} +: 8];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_CLEAR;
            start_reg     <= '0;
            len_reg       <= CW'(NUM_SOURCES);
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            rev_reg       <= 32'd0;
            ctrl_reg      <= 32'd0;
            gen_reg       <= 1'b0;
            host_reg      <= 2'd0;
            vbase_reg     <= 32'd0;
            vstride_reg   <= 32'd0;
            null_reg      <= 32'd0;
            fv_reg        <= 1'b0;
            iv_reg        <= 1'b0;
            vec1_reg      <= 32'd0;
            vec2_reg      <= 32'd0;
            m_valid_reg   <= 1'b0;
            scan_pend_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                rev_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            dv_reg <= (state_reg == S_RUN) || (state_reg == S_CLEAR);

            if (dv_reg && op_reg == OP_SCAN && hit) begin
                if (mem_rdata.ch < 8'd2) begin
                    if (!fv_reg || fch_reg > mem_rdata.ch) begin
                        fv_reg   <= 1'b1;
                        fidx_reg <= d_addr_reg;
                        fch_reg  <= mem_rdata.ch;
                    end
                end else begin
                    if (!iv_reg || ich_reg > mem_rdata.ch) begin
                        iv_reg   <= 1'b1;
                        iidx_reg <= d_addr_reg;
                        ich_reg  <= mem_rdata.ch;
                    end
                end
            end

            // Read data gathered from the memory during bank and map reads.
            if (dv_reg) begin
                unique case (op_reg)
                    OP_RD_PEND:   rd_reg[d_off_reg] <= mem_rdata.pend;
                    OP_RD_PENDEN: rd_reg[d_off_reg] <= hit;
                    OP_RD_EN:     rd_reg[d_off_reg] <= mem_rdata.en;
                    OP_RD_MAP:    rd_reg[{d_off_reg[1:0], 3'b000} +: 8] <= mem_rdata.ch;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_CLEAR, S_RUN: begin
                    cnt_reg <= CW'(cnt_reg + CW'(1));
                    if (cnt_reg == CW'(len_reg - CW'(1))) begin
                        state_reg <= S_WAIT;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg   <= s_tuser;
                        addr_reg  <= s_tdata[31:0];
                        data_reg  <= s_tdata[63:32];
                        src_reg   <= s_tdata[70:64];
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    status_reg    <= dec.status;
                    scan_pend_reg <= dec.scan;
                    single_reg    <= dec.single;
                    rd_reg        <= (act_reg == ACT_READ) ? reg_rd : 32'd0;
                    if (act_reg == ACT_WRITE && dec.status == ST_OK) begin
                        unique case (dec.sel)
                            R_CTRL:    ctrl_reg    <= data_reg;
                            R_GEN:     gen_reg     <= data_reg[0];
                            R_VBASE:   vbase_reg   <= data_reg;
                            R_VSTRIDE: vstride_reg <= data_reg;
                            R_NULL:    null_reg    <= data_reg;
                            R_HOST:    host_reg    <= data_reg[1:0];
                            R_HSET: begin
                                if (data_reg[31:1] == 31'd0) host_reg[data_reg[0]] <= 1'b1;
                            end
                            R_HCLR: begin
                                if (data_reg[31:1] == 31'd0) host_reg[data_reg[0]] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    cnt_reg <= '0;
                    if (dec.op != OP_NONE) begin
                        op_reg    <= dec.op;
                        start_reg <= dec_start;
                        len_reg   <= op_len;
                        state_reg <= S_RUN;
                    end else if (dec.scan) begin
                        op_reg        <= OP_SCAN;
                        start_reg     <= '0;
                        len_reg       <= CW'(NUM_SOURCES);
                        fv_reg        <= 1'b0;
                        iv_reg        <= 1'b0;
                        state_reg     <= S_RUN;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_WAIT: begin
                    cnt_reg <= '0;
                    if (op_reg == OP_CLEAR) begin
                        state_reg <= S_IDLE;
                    end else if (op_reg == OP_SCAN) begin
                        state_reg <= S_VEC_F;
                    end else if (scan_pend_reg) begin
                        op_reg        <= OP_SCAN;
                        start_reg     <= '0;
                        len_reg       <= CW'(NUM_SOURCES);
                        fv_reg        <= 1'b0;
                        iv_reg        <= 1'b0;
                        scan_pend_reg <= 1'b0;
                        state_reg     <= S_RUN;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_VEC_F: begin
                    vec1_reg  <= fv_reg ? 32'(vbase_reg + mul_prod) : null_reg;
                    state_reg <= S_VEC_I;
                end
                S_VEC_I: begin
                    vec2_reg  <= iv_reg ? 32'(vbase_reg + mul_prod) : null_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'd0, status_reg,
                                        gen_reg && iv_reg && host_reg[1],
                                        gen_reg && fv_reg && host_reg[0],
                                        (status_reg == ST_OK) ? rd_reg : 32'd0};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        d_addr_reg <= mem_raddr;
        d_off_reg  <= cnt_reg[4:0];
    end

    `CPIC_ASSERT_NOW(a_ready_no_inflight, s_tready, !dv_reg && !mem_we, "item taken with memory access in flight")
    `CPIC_ASSERT_NOW(a_write_has_data, mem_we, dv_reg, "memory written without returned data")
    `CPIC_ASSERT_NOW(a_fiq_channel, fv_reg, fch_reg < 8'd2, "FIQ winner on a normal channel")
    `CPIC_ASSERT_NOW(a_irq_channel, iv_reg, ich_reg >= 8'd2, "IRQ winner on a fast channel")
    `CPIC_ASSERT_NEXT(a_out_after_vec, state_reg == S_VEC_I, state_reg == S_OUT, "vector step not followed by output")

endmodule

// ===== hdl/cpic_src_ram.sv =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller: source memory
// One entry per source: raw pending, enable and channel. One write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module cpic_src_ram
    import cpic_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_SOURCES,
    parameter int AW    = $clog2(DEF_NUM_SOURCES)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cpic_decode.sv =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller: address decoder
// Classifies one item into a status, a memory operation, a flat register and
// whether a priority scan follows.
// ----------------------------------------------------------------------------
module cpic_decode
    import cpic_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES,
    parameter int AW          = $clog2(DEF_NUM_SOURCES)
) (
    input  logic [1:0]    action,
    input  logic [31:0]   address,
    input  logic [31:0]   write_data,
    input  logic [6:0]    source,
    output dec_t          dec,
    output logic [AW-1:0] start
);

    localparam logic [31:0] NSRC       = 32'(NUM_SOURCES);
    localparam logic [31:0] MAP_WORDS  = 32'(NUM_SOURCES / 4);
    localparam logic [31:0] BANK_WORDS = 32'(NUM_SOURCES / 32);

    logic        is_rd;
    logic        bad;
    logic [5:0]  map_n;
    logic [1:0]  bank_n;

    assign is_rd  = (action == ACT_READ);
    assign bad    = (address[31:16] != 16'd0) || (address[1:0] != 2'd0);
    assign map_n  = address[7:2];
    assign bank_n = address[3:2];

    always_comb begin
        dec.status = ST_OK;
        dec.op     = OP_NONE;
        dec.sel    = R_NONE;
        dec.single = 1'b0;
        dec.scan   = 1'b0;
        start      = '0;
        if (action == ACT_PULSE) begin
            if ({25'd0, source} >= NSRC) begin
                dec.status = ST_BAD_SRC;
            end else begin
                dec.op     = OP_SET_PEND;
                dec.single = 1'b1;
                dec.scan   = 1'b1;
                start      = AW'(source);
            end
        end else if (action == ACT_READ || action == ACT_WRITE) begin
            if (bad) begin
                dec.status = ST_BAD_ADDR;
            end else if (address[15:8] == 8'h04) begin
                if ({26'd0, map_n} >= MAP_WORDS) begin
                    dec.status = ST_BAD_ADDR;
                end else begin
                    dec.op   = is_rd ? OP_RD_MAP : OP_WR_MAP;
                    dec.scan = !is_rd;
                    start    = AW'({map_n, 2'b00});
                end
            end else begin
                unique case (address[15:0])
                    16'h0000: begin
                        if (is_rd) dec.sel = R_REV;
                        else dec.status = ST_RO_WRITE;
                    end
                    16'h0080: begin
                        if (is_rd) dec.sel = R_NUM0;
                        else dec.status = ST_RO_WRITE;
                    end
                    16'h0084: begin
                        if (is_rd) dec.sel = R_VEC0;
                        else dec.status = ST_RO_WRITE;
                    end
                    16'h001C: ;
                    16'h0004: begin dec.sel = R_CTRL;    dec.scan = !is_rd; end
                    16'h0010: begin dec.sel = R_GEN;     dec.scan = !is_rd; end
                    16'h0050: begin dec.sel = R_VBASE;   dec.scan = !is_rd; end
                    16'h0054: begin dec.sel = R_VSTRIDE; dec.scan = !is_rd; end
                    16'h0058: begin dec.sel = R_NULL;    dec.scan = !is_rd; end
                    16'h1500: begin dec.sel = R_HOST;    dec.scan = !is_rd; end
                    16'h0034, 16'h0038: begin
                        if (is_rd) begin
                            dec.status = ST_WO_READ;
                        end else begin
                            dec.sel  = (address[3:2] == 2'd1) ? R_HSET : R_HCLR;
                            dec.scan = 1'b1;
                        end
                    end
                    16'h0020, 16'h0024, 16'h0028, 16'h002C: begin
                        if (is_rd) begin
                            dec.status = ST_WO_READ;
                        end else if (write_data >= NSRC) begin
                            dec.status = ST_BAD_SRC;
                        end else begin
                            unique case (address[3:2])
                                2'd0: dec.op = OP_SET_PEND;
                                2'd1: dec.op = OP_CLR_PEND;
                                2'd2: dec.op = OP_SET_EN;
                                default: dec.op = OP_CLR_EN;
                            endcase
                            dec.single = 1'b1;
                            dec.scan   = 1'b1;
                            start      = AW'(write_data);
                        end
                    end
                    default: begin
                        unique case (address[15:4])
                            12'h020, 12'h028, 12'h030, 12'h038: begin
                                if ({30'd0, bank_n} >= BANK_WORDS) begin
                                    dec.status = ST_BAD_ADDR;
                                end else begin
                                    unique case (address[8:7])
                                        2'd0: dec.op = is_rd ? OP_RD_PEND : OP_SET_PEND;
                                        2'd1: dec.op = is_rd ? OP_RD_PENDEN : OP_CLR_PEND;
                                        2'd2: dec.op = is_rd ? OP_RD_EN : OP_SET_EN;
                                        default: dec.op = is_rd ? OP_RD_EN : OP_CLR_EN;
                                    endcase
                                    dec.scan = !is_rd;
                                    start    = AW'({bank_n, 5'd0});
                                end
                            end
                            12'h090: begin
                                if (address[3]) dec.status = ST_BAD_ADDR;
                                else if (!is_rd) dec.status = ST_RO_WRITE;
                                else dec.sel = address[2] ? R_NUM2 : R_NUM1;
                            end
                            12'h160: begin
                                if (address[3]) dec.status = ST_BAD_ADDR;
                                else if (!is_rd) dec.status = ST_RO_WRITE;
                                else dec.sel = address[2] ? R_VEC2 : R_VEC1;
                            end
                            12'h110: begin
                                if (address[3]) dec.status = ST_BAD_ADDR;
                            end
                            default: dec.status = ST_BAD_ADDR;
                        endcase
                    end
                endcase
            end
        end
    end

endmodule

// ===== sim/cpic_checker.sv =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller: checker
// Watches both channels, predicts each result from its own copy of the
// controller state and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module cpic_checker
    import cpic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSRC = DEF_NUM_SOURCES;
    localparam int QD   = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic        irq;
        logic        fiq;
        logic [31:0] rdata;
    } result_t;

    logic [31:0] revision;
    logic        pend [NSRC];
    logic        en   [NSRC];
    logic [7:0]  chan [NSRC];
    logic        gen;
    logic [1:0]  host;
    logic [31:0] ctrl, vbase, vstride, vnull;
    logic [31:0] win_num [3];
    logic [31:0] win_vec [3];
    result_t     exp_mem [QD];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          exp_cnt = 0;

    assign pending_results = exp_cnt;

    task automatic rescan();
        int fw, iw;
        bit fv, iv;
        fv = 0; iv = 0; fw = 0; iw = 0;
        for (int i = 0; i < NSRC; i++) begin
            if (pend[i] && en[i]) begin
                if (chan[i] < 2) begin
                    if (!fv || chan[fw] > chan[i]) begin fw = i; fv = 1; end
                end else begin
                    if (!iv || chan[iw] > chan[i]) begin iw = i; iv = 1; end
                end
            end
        end
        win_num[1] = fv ? 32'(fw) : NONE_NUMBER;
        win_vec[1] = fv ? vbase + 32'(fw) * vstride : vnull;
        win_num[2] = iv ? 32'(iw) : NONE_NUMBER;
        win_vec[2] = iv ? vbase + 32'(iw) * vstride : vnull;
        if (fv || !iv) begin
            win_num[0] = win_num[1]; win_vec[0] = win_vec[1];
        end else begin
            win_num[0] = win_num[2]; win_vec[0] = win_vec[2];
        end
    endtask

    function automatic logic [31:0] bank_bits(int n, int kind);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 32; k++) begin
            if (kind == 0) w[k] = pend[n*32+k];
            else if (kind == 1) w[k] = pend[n*32+k] & en[n*32+k];
            else w[k] = en[n*32+k];
        end
        return w;
    endfunction

    task automatic reg_read(input logic [31:0] a, output logic [31:0] rd,
                            output logic [2:0] st);
        int n;
        rd = '0;
        st = ST_OK;
        if (a[15:8] == 8'h04) begin
            n = a[7:2];
            if (n >= NSRC/4) st = ST_BAD_ADDR;
            else rd = {chan[n*4+3], chan[n*4+2], chan[n*4+1], chan[n*4]};
            return;
        end
        case (a)
            32'h0000: begin rd = revision; return; end
            32'h0004: begin rd = ctrl; return; end
            32'h0010: begin rd = {31'b0, gen}; return; end
            32'h001C: return;
            32'h0020, 32'h0024, 32'h0028, 32'h002C, 32'h0034, 32'h0038: begin
                st = ST_WO_READ; return;
            end
            32'h0050: begin rd = vbase; return; end
            32'h0054: begin rd = vstride; return; end
            32'h0058: begin rd = vnull; return; end
            32'h0080: begin rd = win_num[0]; return; end
            32'h0084: begin rd = win_vec[0]; return; end
            32'h1500: begin rd = {30'b0, host}; return; end
            default: ;
        endcase
        n = a[3:2];
        case (a & 32'hFFF0)
            32'h0200, 32'h0280, 32'h0300, 32'h0380: begin
                if (n >= NSRC/32) st = ST_BAD_ADDR;
                else if ((a & 32'hFFF0) == 32'h0200) rd = bank_bits(n, 0);
                else if ((a & 32'hFFF0) == 32'h0280) rd = bank_bits(n, 1);
                else rd = bank_bits(n, 2);
            end
            32'h0900: if (n >= 2) st = ST_BAD_ADDR; else rd = win_num[n+1];
            32'h1100: if (n >= 2) st = ST_BAD_ADDR;
            32'h1600: if (n >= 2) st = ST_BAD_ADDR; else rd = win_vec[n+1];
            default: st = ST_BAD_ADDR;
        endcase
    endtask

    task automatic reg_write(input logic [31:0] a, input logic [31:0] d,
                             output logic [2:0] st);
        int n;
        st = ST_OK;
        if (a[15:8] == 8'h04) begin
            n = a[7:2];
            if (n >= NSRC/4) st = ST_BAD_ADDR;
            else begin
                for (int k = 0; k < 4; k++) chan[n*4+k] = d[8*k +: 8];
                rescan();
            end
            return;
        end
        case (a)
            32'h0000, 32'h0080, 32'h0084: begin st = ST_RO_WRITE; return; end
            32'h001C: return;
            32'h0004: begin ctrl = d; rescan(); return; end
            32'h0010: begin gen = d[0]; rescan(); return; end
            32'h0034, 32'h0038: begin
                if (d < 2) begin
                    if (a == 32'h0034) host[d[0]] = 1'b1;
                    else host[d[0]] = 1'b0;
                end
                rescan();
                return;
            end
            32'h0020, 32'h0024, 32'h0028, 32'h002C: begin
                if (d >= NSRC) begin st = ST_BAD_SRC; return; end
                if (a == 32'h0020) pend[d] = 1'b1;
                else if (a == 32'h0024) pend[d] = 1'b0;
                else if (a == 32'h0028) en[d] = 1'b1;
                else en[d] = 1'b0;
                rescan();
                return;
            end
            32'h0050: begin vbase = d; rescan(); return; end
            32'h0054: begin vstride = d; rescan(); return; end
            32'h0058: begin vnull = d; rescan(); return; end
            32'h1500: begin host = d[1:0]; rescan(); return; end
            default: ;
        endcase
        n = a[3:2];
        case (a & 32'hFFF0)
            32'h0200, 32'h0280, 32'h0300, 32'h0380: begin
                if (n >= NSRC/32) begin st = ST_BAD_ADDR; return; end
                for (int k = 0; k < 32; k++) begin
                    if (d[k]) begin
                        case (a & 32'hFFF0)
                            32'h0200: pend[n*32+k] = 1'b1;
                            32'h0280: pend[n*32+k] = 1'b0;
                            32'h0300: en[n*32+k] = 1'b1;
                            default:  en[n*32+k] = 1'b0;
                        endcase
                    end
                end
                rescan();
            end
            32'h0900, 32'h1600: st = (n >= 2) ? ST_BAD_ADDR : ST_RO_WRITE;
            32'h1100: st = (n >= 2) ? ST_BAD_ADDR : ST_OK;
            default: st = ST_BAD_ADDR;
        endcase
    endtask

    task automatic predict_item(input logic [1:0] act, input logic [71:0] d);
        result_t r;
        logic [31:0] a;
        logic [2:0]  st;
        logic [31:0] rd;
        a = d[31:0];
        rd = '0;
        st = ST_OK;
        if (act == ACT_READ) begin
            if (a[31:16] != 0 || a[1:0] != 0) st = ST_BAD_ADDR;
            else reg_read(a, rd, st);
        end else if (act == ACT_WRITE) begin
            if (a[31:16] != 0 || a[1:0] != 0) st = ST_BAD_ADDR;
            else reg_write(a, d[63:32], st);
        end else if (act == ACT_PULSE) begin
            pend[d[70:64]] = 1'b1;
            rescan();
        end
        if (st != ST_OK) rd = '0;
        r.rdata  = rd;
        r.status = st;
        r.fiq    = gen && win_num[1] != NONE_NUMBER && host[0];
        r.irq    = gen && win_num[2] != NONE_NUMBER && host[1];
        if (exp_cnt == QD) begin
            $display("%0t: expected results overflow, expected at most %0d, actual %0d",
                     $time, QD, exp_cnt + 1);
            fail_count <= fail_count + 1;
        end else begin
            exp_mem[exp_wr] = r;
            exp_wr = (exp_wr + 1) % QD;
            exp_cnt = exp_cnt + 1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            revision = '0;
            for (int i = 0; i < NSRC; i++) begin
                pend[i] = 0; en[i] = 0; chan[i] = '0;
            end
            gen = 0; host = '0; ctrl = '0; vbase = '0; vstride = '0; vnull = '0;
            for (int i = 0; i < 3; i++) begin
                win_num[i] = NONE_NUMBER; win_vec[i] = '0;
            end
            exp_wr = 0;
            exp_rd = 0;
            exp_cnt = 0;
            fail_count <= 0;
        end else begin
            if (cfg_wen) revision = cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (exp_cnt == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    result_t e;
                    e = exp_mem[exp_rd];
                    exp_rd = (exp_rd + 1) % QD;
                    exp_cnt = exp_cnt - 1;
                    if (m_tdata[31:0] !== e.rdata || m_tdata[32] !== e.fiq ||
                        m_tdata[33] !== e.irq || m_tdata[36:34] !== e.status) begin
                        $display("%0t: expected rd=%h fiq=%b irq=%b st=%0d, actual %h",
                                 $time, e.rdata, e.fiq, e.irq, e.status, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
        end
    end

    final begin
        if (exp_cnt != 0)
            $display("%0t: %0d results never arrived", $time, exp_cnt);
    end
endmodule

// ===== sim/tb_channel_priority_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// Channel priority interrupt controller: testbench
// Drives directed and random register reads, writes and line pulses with
// random gaps and backpressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_channel_priority_interrupt_controller;
    import cpic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wen = 0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    int          fail_count;
    int          pending_results;
    int          idle_cycles = 0;
    bit          sink_running = 0;

    always #6 aclk = ~aclk;

    channel_priority_interrupt_controller DUT (.*);

    cpic_checker checker_i (.*);

    // Count cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("channel_priority_interrupt_controller: mismatch");
            $finish;
        end
    end

    // Result side: random stalls drawn per transfer.
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = sink_running ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send(input logic [1:0] act, input logic [31:0] a,
                        input logic [31:0] d, input logic [6:0] src, input bit nogap);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, src, d, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_results != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_revision(input logic [31:0] v);
        cfg_wen   <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 0;
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        case ($urandom_range(0, 15))
            0: a = 32'h0400 + 4 * $urandom_range(0, 33);
            1, 2: a = 32'h0200 + 32'h80 * $urandom_range(0, 3) + 4 * $urandom_range(0, 4);
            3: a = 32'h0900 + 4 * $urandom_range(0, 4);
            4: a = 32'h1600 + 4 * $urandom_range(0, 4);
            5: a = 32'h1100 + 4 * $urandom_range(0, 4);
            6: a = $urandom();
            7: a = $urandom_range(0, 32'hFFFF);
            default: begin
                case ($urandom_range(0, 13))
                    0: a = 32'h0000; 1: a = 32'h0004; 2: a = 32'h0010;
                    3: a = 32'h001C; 4: a = 32'h0020 + 4 * $urandom_range(0, 3);
                    5: a = 32'h0034; 6: a = 32'h0038; 7: a = 32'h0050;
                    8: a = 32'h0054; 9: a = 32'h0058; 10: a = 32'h0080;
                    11: a = 32'h0084; 12: a = 32'h1500; default: a = 32'hFFF0;
                endcase
            end
        endcase
        return a;
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 127);
            1: return $urandom_range(0, 2);
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 255);
            4: return $urandom_range(128, 300);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [1:0]  act;
        logic [31:0] a;
        bit          burst;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        set_revision(32'h0000_0000);

        // Directed: bring the controller up and touch each special case.
        send(ACT_READ,  32'h0000, 0, 0, 0);
        send(ACT_WRITE, 32'h0010, 32'hFFFF_FFFF, 0, 0);
        send(ACT_WRITE, 32'h1500, 32'h3, 0, 0);
        send(ACT_WRITE, 32'h0054, 32'h10, 0, 0);
        send(ACT_WRITE, 32'h0050, 32'hFFFF_FF00, 0, 0);
        send(ACT_WRITE, 32'h0058, 32'hDEAD_BEEF, 0, 0);
        send(ACT_WRITE, 32'h0404, 32'h0301_0002, 0, 0);
        send(ACT_WRITE, 32'h0300, 32'hFFFF_FFFF, 0, 0);
        send(ACT_PULSE, 0, 0, 7'd5, 0);
        send(ACT_PULSE, 0, 0, 7'd127, 0);
        send(ACT_WRITE, 32'h0028, 32'd127, 0, 0);
        send(ACT_WRITE, 32'h0028, 32'd128, 0, 0);
        send(ACT_READ,  32'h0084, 0, 0, 0);
        send(ACT_READ,  32'h0900, 0, 0, 0);
        send(ACT_READ,  32'h1604, 0, 0, 0);
        send(ACT_WRITE, 32'h0080, 1, 0, 0);
        send(ACT_READ,  32'h0020, 0, 0, 0);
        send(ACT_READ,  32'h0002, 0, 0, 0);
        send(ACT_READ,  32'h0001_0000, 0, 0, 0);
        send(ACT_WRITE, 32'h0034, 32'd7, 0, 0);
        send(ACT_WRITE, 32'h1104, 32'h1, 0, 0);
        send(ACT_WRITE, 32'h0480, 32'h1, 0, 0);
        send(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 0);
        send(ACT_READ,  32'h0280, 0, 0, 0);
        drain();
        set_revision(32'hFFFF_FFFF);

        for (int phase = 0; phase < 3; phase++) begin
            for (int i = 0; i < 550; i++) begin
                burst = (i % 100) < 20;
                act = $urandom_range(0, 9) < 4 ? ACT_PULSE : $urandom_range(0, 9) == 0
                      ? ACT_NONE : ($urandom_range(0, 1) ? ACT_WRITE : ACT_READ);
                a = pick_addr();
                sink_running = burst;
                send(act, a, pick_data(), 7'($urandom_range(0, 127)), burst);
            end
            sink_running = 0;
            drain();
            if (phase == 0) set_revision($urandom());
            else set_revision(32'h0000_0000);
            send(ACT_READ, 32'h0000, 0, 0, 0);
        end
        drain();
        if (fail_count == 0)
            $display("channel_priority_interrupt_controller: match");
        else
            $display("channel_priority_interrupt_controller: mismatch");
        $finish;
    end
endmodule
